// ----- sv/clr_pkg.sv -----
// shared types and constants of the clipped line rasterizer
`default_nettype none

package clr_pkg;

  // clamp limits applied to incoming rows
  localparam logic signed [7:0] Y_LOW  = -8'sd48;
  localparam logic signed [7:0] Y_HIGH = 8'sd79;

  // reset values of the clip registers
  localparam logic [7:0] CLIP_WIDTH_RESET  = 8'd128;
  localparam logic [6:0] CLIP_HEIGHT_RESET = 7'd32;

  // configuration register indexes
  localparam logic CFG_CLIP_WIDTH  = 1'b0;
  localparam logic CFG_CLIP_HEIGHT = 1'b1;

  // depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // a classified line command ready for the walker
  typedef struct packed {
    logic [6:0]        x0;
    logic signed [7:0] y0;
    logic [6:0]        x1;
    logic signed [7:0] y1;
    logic signed [7:0] dx;      // |x1 - x0|
    logic signed [7:0] dy;      // -|y1 - y0|
    logic              sx_neg;
    logic              sy_neg;
    logic signed [9:0] err;
  } line_cmd_t;

endpackage

`default_nettype wire

// ----- sv/clipped_line_rasterizer.sv -----
// top level of the clipped line rasterizer
// A line command is taken whenever the two-entry command queue has room; the
// walker then loads it and emits one result per cycle while not stalled,
// each with up to two points of the Bresenham walk (one when POINTS_PER_RESULT
// is 1). The walker chains two error-rule steps from the current point. Rows
// are clamped to -48..79 on input. The user must write the clip registers
// (index 0 width, index 1 height) only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module clipped_line_rasterizer #(
  parameter int unsigned POINTS_PER_RESULT = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [6:0]        start_x_i,
  input  logic signed [7:0] start_y_i,
  input  logic [6:0]        end_x_i,
  input  logic signed [7:0] end_y_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [6:0]        first_px_x_o,
  output logic signed [7:0] first_px_y_o,
  output logic              first_px_shown_o,
  output logic              second_px_used_o,
  output logic [6:0]        second_px_x_o,
  output logic signed [7:0] second_px_y_o,
  output logic              second_px_shown_o,
  output logic              final_flag_o
);
  import clr_pkg::*;

  logic [7:0] clip_width_q;
  logic [6:0] clip_height_q;
  line_cmd_t  front_cmd;
  line_cmd_t  queue_cmd;
  logic       queue_full;
  logic       queue_valid;
  logic       queue_pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = queue_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_width_q  <= CLIP_WIDTH_RESET;
      clip_height_q <= CLIP_HEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CLIP_WIDTH:  clip_width_q  <= cfg_data_i;
        CFG_CLIP_HEIGHT: clip_height_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  clr_front u_front (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .cmd_o     (front_cmd)
  );

  clr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_cmd)
  );

  clr_back #(
    .POINTS_PER_RESULT (POINTS_PER_RESULT)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (queue_valid),
    .cmd_i             (queue_cmd),
    .cmd_pop_o         (queue_pop),
    .clip_width_i      (clip_width_q),
    .clip_height_i     (clip_height_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .first_px_x_o      (first_px_x_o),
    .first_px_y_o      (first_px_y_o),
    .first_px_shown_o  (first_px_shown_o),
    .second_px_used_o  (second_px_used_o),
    .second_px_x_o     (second_px_x_o),
    .second_px_y_o     (second_px_y_o),
    .second_px_shown_o (second_px_shown_o),
    .final_flag_o      (final_flag_o)
  );

endmodule

`default_nettype wire

// ----- sv/clr_front.sv -----
// front end: clamps the rows and sets up the walk parameters of a command
`default_nettype none

module clr_front (
  input  logic [6:0]        start_x_i,
  input  logic signed [7:0] start_y_i,
  input  logic [6:0]        end_x_i,
  input  logic signed [7:0] end_y_i,
  output clr_pkg::line_cmd_t cmd_o
);
  import clr_pkg::*;

  logic signed [7:0] y0;
  logic signed [7:0] y1;
  logic signed [7:0] dx_raw;
  logic signed [8:0] dy_raw;
  logic signed [7:0] dx_abs;
  logic signed [8:0] dy_abs;

  always_comb begin
    y0 = start_y_i;
    if (start_y_i < Y_LOW) y0 = Y_LOW;
    else if (start_y_i > Y_HIGH) y0 = Y_HIGH;
    y1 = end_y_i;
    if (end_y_i < Y_LOW) y1 = Y_LOW;
    else if (end_y_i > Y_HIGH) y1 = Y_HIGH;

    dx_raw = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
    dx_abs = dx_raw[7] ? -dx_raw : dx_raw;
    dy_raw = {y1[7], y1} - {y0[7], y0};
    dy_abs = dy_raw[8] ? -dy_raw : dy_raw;

    cmd_o.x0     = start_x_i;
    cmd_o.y0     = y0;
    cmd_o.x1     = end_x_i;
    cmd_o.y1     = y1;
    cmd_o.dx     = dx_abs;
    cmd_o.dy     = 8'(-dy_abs);
    cmd_o.sx_neg = !(start_x_i < end_x_i);
    cmd_o.sy_neg = !(y0 < y1);
    cmd_o.err    = {{2{dx_abs[7]}}, dx_abs} + 10'(-dy_abs);
  end

endmodule

`default_nettype wire

// ----- sv/clr_queue.sv -----
// short command queue between the front end and the walker
`default_nettype none

module clr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  clr_pkg::line_cmd_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output clr_pkg::line_cmd_t pop_data_o
);
  import clr_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  line_cmd_t         mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

// ----- sv/clr_back.sv -----
// back end: bresenham walker that packs points into result transfers
`default_nettype none

module clr_back #(
  parameter int unsigned POINTS_PER_RESULT = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  clr_pkg::line_cmd_t cmd_i,
  output logic               cmd_pop_o,
  input  logic [7:0]         clip_width_i,
  input  logic [6:0]         clip_height_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [6:0]         first_px_x_o,
  output logic signed [7:0]  first_px_y_o,
  output logic               first_px_shown_o,
  output logic               second_px_used_o,
  output logic [6:0]         second_px_x_o,
  output logic signed [7:0]  second_px_y_o,
  output logic               second_px_shown_o,
  output logic               final_flag_o
);
  import clr_pkg::*;

  localparam bit TwoSlots = (POINTS_PER_RESULT >= 2);

  typedef struct packed {
    logic [6:0]        x;
    logic signed [7:0] y;
    logic signed [9:0] err;
  } walk_pt_t;

  line_cmd_t cmd_q, cmd_d;
  walk_pt_t  pt_q, pt_d;
  logic      busy_q, busy_d;

  logic      out_valid_q, out_valid_d;
  logic [6:0]        fx_q, fx_d, sx_q, sx_d;
  logic signed [7:0] fy_q, fy_d, sy_q, sy_d;
  logic      fshow_q, fshow_d, sused_q, sused_d, sshow_q, sshow_d, fin_q, fin_d;

  walk_pt_t  pt_b, pt_c;
  logic      done_a, done_b, emit;

  // one error-rule step from a point
  function automatic walk_pt_t step(walk_pt_t p, line_cmd_t c);
    logic signed [10:0] e2;
    walk_pt_t           n;
    e2 = {p.err, 1'b0};
    n  = p;
    if (e2 >= 11'(c.dy)) begin
      n.err = n.err + 10'(c.dy);
      n.x   = c.sx_neg ? p.x - 1'b1 : p.x + 1'b1;
    end
    if (e2 <= 11'(c.dx)) begin
      n.err = n.err + 10'(c.dx);
      n.y   = c.sy_neg ? p.y - 8'sd1 : p.y + 8'sd1;
    end
    step = n;
  endfunction

  function automatic logic shown(logic [6:0] x, logic signed [7:0] y,
                                 logic [7:0] w, logic [6:0] h);
    shown = ({1'b0, x} < w) && !y[7] && (y[6:0] < h);
  endfunction

  assign cmd_pop_o = !busy_q && cmd_valid_i;
  assign emit      = busy_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    pt_b   = step(pt_q, cmd_q);
    pt_c   = step(pt_b, cmd_q);
    done_a = (pt_q.x == cmd_q.x1) && (pt_q.y == cmd_q.y1);
    done_b = (pt_b.x == cmd_q.x1) && (pt_b.y == cmd_q.y1);

    cmd_d       = cmd_q;
    pt_d        = pt_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && out_stall_i;
    fx_d = fx_q; fy_d = fy_q; fshow_d = fshow_q;
    sused_d = sused_q; sx_d = sx_q; sy_d = sy_q; sshow_d = sshow_q; fin_d = fin_q;

    if (cmd_pop_o) begin
      cmd_d  = cmd_i;
      pt_d.x = cmd_i.x0;
      pt_d.y = cmd_i.y0;
      pt_d.err = cmd_i.err;
      busy_d = 1'b1;
    end else if (emit) begin
      out_valid_d = 1'b1;
      fx_d    = pt_q.x;
      fy_d    = pt_q.y;
      fshow_d = shown(pt_q.x, pt_q.y, clip_width_i, clip_height_i);
      if (TwoSlots && !done_a) begin
        sused_d = 1'b1;
        sx_d    = pt_b.x;
        sy_d    = pt_b.y;
        sshow_d = shown(pt_b.x, pt_b.y, clip_width_i, clip_height_i);
        fin_d   = done_b;
        pt_d    = pt_c;
        busy_d  = !done_b;
      end else begin
        // odd point count or single slot: second slot stays empty
        sused_d = 1'b0;
        sx_d    = '0;
        sy_d    = '0;
        sshow_d = 1'b0;
        fin_d   = done_a;
        pt_d    = pt_b;
        busy_d  = !done_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    pt_q    <= pt_d;
    fx_q    <= fx_d;
    fy_q    <= fy_d;
    fshow_q <= fshow_d;
    sused_q <= sused_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    sshow_q <= sshow_d;
    fin_q   <= fin_d;
  end

  assign out_valid_o       = out_valid_q;
  assign first_px_x_o      = fx_q;
  assign first_px_y_o      = fy_q;
  assign first_px_shown_o  = fshow_q;
  assign second_px_used_o  = sused_q;
  assign second_px_x_o     = sx_q;
  assign second_px_y_o     = sy_q;
  assign second_px_shown_o = sshow_q;
  assign final_flag_o      = fin_q;

endmodule

`default_nettype wire

// ----- sv/clr_checker.sv -----
// port checker of the clipped line rasterizer and its bind
`default_nettype none

module clr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [6:0]        first_px_x_o,
  input logic signed [7:0] first_px_y_o,
  input logic              first_px_shown_o,
  input logic              second_px_used_o,
  input logic [6:0]        second_px_x_o,
  input logic signed [7:0] second_px_y_o,
  input logic              second_px_shown_o,
  input logic              final_flag_o
);

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(first_px_x_o) &&
      $stable(first_px_y_o) && $stable(second_px_used_o) && $stable(final_flag_o))
    else $error("result changed while stalled");

  // an empty second slot reads as zeros
  a_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !second_px_used_o |-> second_px_x_o == 7'd0 &&
      second_px_y_o == 8'sd0 && !second_px_shown_o)
    else $error("unused second slot not cleared");

  // a shown point never sits on a negative row
  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_px_shown_o |-> !first_px_y_o[7])
    else $error("first point shown on a negative row");

  a_second_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && second_px_shown_o |-> second_px_used_o && !second_px_y_o[7])
    else $error("second point shown while unused or off screen");

endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .first_px_x_o      (first_px_x_o),
  .first_px_y_o      (first_px_y_o),
  .first_px_shown_o  (first_px_shown_o),
  .second_px_used_o  (second_px_used_o),
  .second_px_x_o     (second_px_x_o),
  .second_px_y_o     (second_px_y_o),
  .second_px_shown_o (second_px_shown_o),
  .final_flag_o      (final_flag_o)
);

`default_nettype wire
